FILE: src/hsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsm_pkg: shared types and constants for the Hermitian symmetry mapper
// Sample and result payload types, front-to-back control and queue status.
// ----------------------------------------------------------------------------
package hsm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CFG_BITS = 4;
	localparam int CFG_IDX_BITS = 1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FFT_LOG2 = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIRROR_MODE = 1'd1;

	localparam logic [3:0] MIN_LOG2 = 4'd2;
	localparam logic [3:0] FFT_LOG2_RESET = 4'd6;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int LVL_BITS = $clog2(FIFO_DEPTH + 3);

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_re;
		logic signed [SAMPLE_BITS-1:0] sample_im;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_re;
		logic signed [SAMPLE_BITS-1:0] out_im;
		logic                          out_last;
		logic                          frame_valid;
	} result_t;

	// classification of one request, aligned with the bank read data
	typedef struct packed {
		logic valid;
		logic zero;
		logic negate;
		logic last;
		logic frame_valid;
	} ctrl_t;

	typedef struct packed {
		logic                room;
		logic [LVL_BITS-1:0] level;
	} back_stat_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_neg(
		input logic signed [SAMPLE_BITS-1:0] x
	);
		logic signed [SAMPLE_BITS-1:0] r;
		if (x == SAMPLE_MIN) begin
			r = SAMPLE_MAX;
		end else begin
			r = -x;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/hsm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/hsm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsm_front: request intake and bin classification
// Holds the registers, bin counter and bank select, drives the bank RAM and
// runs the clearing sweep after reset.
// ----------------------------------------------------------------------------
module hsm_front #(
	parameter int MAX_FFT_LEN = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [hsm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [hsm_pkg::CFG_BITS-1:0]          cfg_data,
	input  wire logic                                  sample_valid,
	output      logic                                  sample_stall,
	input  wire hsm_pkg::sample_t                      sample,
	input  wire logic                                  room,
	output      logic                                  ram_we,
	output      logic [$clog2(2*MAX_FFT_LEN)-1:0]      ram_waddr,
	output      logic [2*hsm_pkg::SAMPLE_BITS-1:0]     ram_wdata,
	output      logic                                  ram_re,
	output      logic [$clog2(2*MAX_FFT_LEN)-1:0]      ram_raddr,
	output      hsm_pkg::ctrl_t                        ctrl_s1
);
	import hsm_pkg::*;

	localparam int LW = $clog2(MAX_FFT_LEN);
	localparam int AW = LW + 1;
	localparam logic [3:0] MAX_L = 4'(LW);

	logic [3:0]    fft_log2_q;
	logic          mirror_mode_q;
	logic [LW-1:0] pos_q;
	logic          wr_bank_q;
	logic          have_frame_q;
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	logic [3:0]    len_log2;
	logic [LW:0]   n;
	logic [LW-1:0] mask;
	logic [LW-1:0] half;
	logic [LW-1:0] k;
	logic [LW-1:0] src;
	logic          last;
	logic          zero;
	logic          keep;
	logic          accept;

	always_comb begin
		if (fft_log2_q < MIN_LOG2) begin
			len_log2 = MIN_LOG2;
		end else if (fft_log2_q > MAX_L) begin
			len_log2 = MAX_L;
		end else begin
			len_log2 = fft_log2_q;
		end
		n    = (LW+1)'(1) << len_log2;
		mask = n[LW-1:0] - LW'(1);
		half = n[LW:1];
		k    = ({1'b0, pos_q} >= n) ? '0 : pos_q;
		src  = (LW'(0) - k) & mask;
		last = (k == mask);
		zero = (k == '0) || (k == half);
		keep = mirror_mode_q ? (k > half) : (k < half);
	end

	assign sample_stall = clearing_q || !room;
	assign accept       = sample_valid && !sample_stall;

	// bank access: the read bank is always the one not being filled
	assign ram_re    = accept;
	assign ram_raddr = {~wr_bank_q, keep ? k : src};
	assign ram_we    = clearing_q || accept;
	assign ram_waddr = clearing_q ? clr_cnt_q : {wr_bank_q, k};
	assign ram_wdata = clearing_q ? '0 : {sample.sample_re, sample.sample_im};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_log2_q    <= FFT_LOG2_RESET;
			mirror_mode_q <= 1'b0;
			pos_q         <= '0;
			wr_bank_q     <= 1'b0;
			have_frame_q  <= 1'b0;
			clearing_q    <= 1'b1;
			clr_cnt_q     <= '0;
			ctrl_s1       <= '0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == {AW{1'b1}}) begin
					clearing_q <= 1'b0;
				end
			end
			ctrl_s1.valid <= accept;
			if (accept) begin
				ctrl_s1.zero        <= zero;
				ctrl_s1.negate      <= !zero && !keep;
				ctrl_s1.last        <= last;
				ctrl_s1.frame_valid <= have_frame_q;
				if (last) begin
					pos_q        <= '0;
					wr_bank_q    <= ~wr_bank_q;
					have_frame_q <= 1'b1;
				end else begin
					pos_q <= k + LW'(1);
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FFT_LOG2: begin
						fft_log2_q <= cfg_data;
						pos_q      <= '0;
					end
					REG_MIRROR_MODE: begin
						mirror_mode_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/hsm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsm_back: symmetry fix-up and result queue
// Zeroes or conjugates the bank read data and queues the result so the
// output side can stall without holding up the front.
// ----------------------------------------------------------------------------
module hsm_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire hsm_pkg::ctrl_t                    ctrl_s1,
	input  wire logic [2*hsm_pkg::SAMPLE_BITS-1:0] ram_rdata,
	output      hsm_pkg::back_stat_t               stat,
	output      logic                              result_valid,
	input  wire logic                              result_stall,
	output      hsm_pkg::result_t                  result
);
	import hsm_pkg::*;

	result_t             fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [LVL_BITS-1:0] level_q;
	result_t             fixed;
	logic signed [SAMPLE_BITS-1:0] rd_re;
	logic signed [SAMPLE_BITS-1:0] rd_im;
	logic                push;
	logic                pop;

	assign rd_re = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign rd_im = ram_rdata[SAMPLE_BITS-1:0];

	always_comb begin
		fixed.out_last    = ctrl_s1.last;
		fixed.frame_valid = ctrl_s1.frame_valid;
		if (ctrl_s1.zero) begin
			fixed.out_re = '0;
			fixed.out_im = '0;
		end else begin
			fixed.out_re = rd_re;
			fixed.out_im = ctrl_s1.negate ? sat_neg(rd_im) : rd_im;
		end
	end

	assign push         = ctrl_s1.valid;
	assign result_valid = (level_q != '0);
	assign pop          = result_valid && !result_stall;
	assign result       = fifo_q[rd_ptr_q];

	// room for a new request counting the one still in the read stage
	assign stat.level = level_q;
	assign stat.room  = (level_q + LVL_BITS'(ctrl_s1.valid)) < LVL_BITS'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= fixed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			level_q <= level_q + LVL_BITS'(push) - LVL_BITS'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: src/hermitian_symmetry_mapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hermitian_symmetry_mapper: Hermitian symmetry subcarrier mapper
// Ping-pong frame banks; each request writes one bin k and returns bin k of
// the previous frame, or for the mirrored half the conjugate of bin N-k, with
// bins 0 and N/2 zeroed.
//
//   channel   handshake                  payload
//   sample    sample_valid/sample_stall  sample (sample_re, sample_im)
//   result    result_valid/result_stall  result (out_re, out_im, out_last,
//                                               frame_valid)
//   config    cfg_we                     cfg_index, cfg_data
//
// One request per cycle while sample_stall is low; the bank RAM has a read
// and a write port, so a bin is read and written in the same cycle. A result
// is shown after its request passes the registered RAM read and the result
// queue. After reset a clearing sweep zeroes both banks with sample_stall
// high. The result queue holds four results; while result_stall is high,
// sample_stall rises once the queue and the read stage together hold four.
// ----------------------------------------------------------------------------
module hermitian_symmetry_mapper #(
	parameter int MAX_FFT_LEN = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [hsm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [hsm_pkg::CFG_BITS-1:0]     cfg_data,
	input  wire logic                             sample_valid,
	output      logic                             sample_stall,
	input  wire hsm_pkg::sample_t                 sample,
	output      logic                             result_valid,
	input  wire logic                             result_stall,
	output      hsm_pkg::result_t                 result
);
	import hsm_pkg::*;

	localparam int RAM_DEPTH = 2 * MAX_FFT_LEN;
	localparam int RAM_AW = $clog2(RAM_DEPTH);

	logic                     ram_we;
	logic [RAM_AW-1:0]        ram_waddr;
	logic [2*SAMPLE_BITS-1:0] ram_wdata;
	logic                     ram_re;
	logic [RAM_AW-1:0]        ram_raddr;
	logic [2*SAMPLE_BITS-1:0] ram_rdata;
	ctrl_t                    ctrl_s1;
	back_stat_t               stat;
	logic                     sample_accept;

	assign sample_accept = sample_valid && !sample_stall;

	hsm_front #(
		.MAX_FFT_LEN(MAX_FFT_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.room        (stat.room),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ctrl_s1     (ctrl_s1)
	);

	hsm_ram #(
		.WIDTH(2 * SAMPLE_BITS),
		.DEPTH(RAM_DEPTH)
	) u_banks (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	hsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl_s1     (ctrl_s1),
		.ram_rdata   (ram_rdata),
		.stat        (stat),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

`ifndef SYNTH
	// every accepted request reaches the back stage on the next cycle
	a_accept_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		sample_accept |=> ctrl_s1.valid)
		else $error("accepted request did not reach back stage");

	// nothing enters the back stage without a request
	a_back_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s1.valid |-> $past(sample_accept))
		else $error("back stage item without a request");

	// result queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= LVL_BITS'(FIFO_DEPTH))
		else $error("result queue overflow");
`endif

endmodule
`default_nettype wire
